@@ rtl/quadratic_root_solver_unit_defines.svh @@
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked in and out of reset
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/qrs_pkg.sv @@
// types, widths and codes shared by the quadratic root solver
`default_nettype none
package qrs_pkg;

  localparam int COEF_WIDTH   = 16;
  localparam int RESULT_WIDTH = 32;
  localparam int RESULT_FRAC  = RESULT_WIDTH / 2;

  localparam int PROD_W = 2 * COEF_WIDTH;
  localparam int DISC_W = 2 * COEF_WIDTH + 2;
  localparam int DMAG_W = 2 * COEF_WIDTH + 1;
  localparam int SQRT_W = (DMAG_W + 2 * RESULT_FRAC + 1) / 2;
  localparam int DPAD_W = 2 * (SQRT_W - RESULT_FRAC);
  localparam int SREM_W = SQRT_W + 2;
  localparam int NB_W   = COEF_WIDTH + RESULT_FRAC + 1;
  localparam int DIVS_W = COEF_WIDTH + 1;
  localparam int NUM_W  = SQRT_W + 1;

  localparam logic [1:0] KIND_TWO_REAL = 2'd0;
  localparam logic [1:0] KIND_DOUBLE   = 2'd1;
  localparam logic [1:0] KIND_COMPLEX  = 2'd2;
  localparam logic [1:0] KIND_DEGEN    = 2'd3;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]                     root_kind;
    logic signed [RESULT_WIDTH-1:0] first_value;
    logic signed [RESULT_WIDTH-1:0] second_value;
    logic                           saturated;
  } qrs_out_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [NB_W-1:0]   nb;
    logic signed [DIVS_W-1:0] two_a;
  } qrs_sq_side_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] neg;
  } qrs_div_side_t;

endpackage
`default_nettype wire

@@ rtl/qrs_sqrt.sv @@
// pipelined bit-serial square root, one root bit per stage
`default_nettype none
module qrs_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [qrs_pkg::DMAG_W-1:0]    in_dmag,
  input  wire qrs_pkg::qrs_sq_side_t         in_side,
  output logic                               out_valid,
  output logic [qrs_pkg::SQRT_W-1:0]         out_root,
  output qrs_pkg::qrs_sq_side_t              out_side
);

  localparam int SW = qrs_pkg::SQRT_W;
  localparam int RW = qrs_pkg::SREM_W;
  localparam int PW = qrs_pkg::DPAD_W;

  logic                  valid_r [0:SW-1];
  logic [PW-1:0]         rad_r   [0:SW-1];
  logic [RW-1:0]         rem_r   [0:SW-1];
  logic [SW-1:0]         root_r  [0:SW-1];
  qrs_pkg::qrs_sq_side_t side_r  [0:SW-1];

  genvar k;
  generate
    for (k = 0; k < SW; k++) begin : g_stage
      logic                  valid_in;
      logic [PW-1:0]         rad_in;
      logic [RW-1:0]         rem_in;
      logic [SW-1:0]         root_in;
      qrs_pkg::qrs_sq_side_t side_in;
      logic [1:0]            pair;
      logic [RW+1:0]         rem_sh;
      logic [RW+1:0]         trial;
      logic [RW+1:0]         diff;
      logic                  ge;

      if (k == 0) begin : g_first
        assign valid_in = in_valid;
        assign rad_in   = {{(PW-qrs_pkg::DMAG_W){1'b0}}, in_dmag};
        assign rem_in   = '0;
        assign root_in  = '0;
        assign side_in  = in_side;
      end else begin : g_next
        assign valid_in = valid_r[k-1];
        assign rad_in   = rad_r[k-1];
        assign rem_in   = rem_r[k-1];
        assign root_in  = root_r[k-1];
        assign side_in  = side_r[k-1];
      end

      // low radicand pairs are the zero fraction padding
      if (SW - 1 - k >= qrs_pkg::RESULT_FRAC) begin : g_pair
        assign pair = rad_in[2*(SW-1-k-qrs_pkg::RESULT_FRAC)+1 -: 2];
      end else begin : g_zero
        assign pair = 2'b00;
      end

      assign rem_sh = {rem_in, pair};
      assign trial  = {{(RW-SW){1'b0}}, root_in, 2'b01};
      assign ge     = rem_sh >= trial;
      assign diff   = rem_sh - trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else begin
          valid_r[k] <= valid_in;
        end
      end

      always_ff @(posedge clk) begin
        rad_r[k]  <= rad_in;
        rem_r[k]  <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
        root_r[k] <= {root_in[SW-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  endgenerate

  assign out_valid = valid_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_side  = side_r[SW-1];

endmodule
`default_nettype wire

@@ rtl/qrs_div.sv @@
// pipelined restoring divider, two lanes sharing one divisor
`default_nettype none
module qrs_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic [1:0][qrs_pkg::NUM_W-1:0]      in_num,
  input  wire logic [qrs_pkg::DIVS_W-1:0]          in_dvs,
  input  wire qrs_pkg::qrs_div_side_t              in_side,
  output logic                                     out_valid,
  output logic [1:0][qrs_pkg::NUM_W-1:0]           out_quo,
  output qrs_pkg::qrs_div_side_t                   out_side
);

  localparam int NW = qrs_pkg::NUM_W;
  localparam int DW = qrs_pkg::DIVS_W;

  logic                   valid_r [0:NW-1];
  logic [1:0][NW-1:0]     nq_r    [0:NW-1];
  logic [1:0][DW-1:0]     rem_r   [0:NW-1];
  logic [DW-1:0]          dvs_r   [0:NW-1];
  qrs_pkg::qrs_div_side_t side_r  [0:NW-1];

  genvar k;
  generate
    for (k = 0; k < NW; k++) begin : g_stage
      logic                   valid_in;
      logic [1:0][NW-1:0]     nq_in;
      logic [1:0][DW-1:0]     rem_in;
      logic [DW-1:0]          dvs_in;
      qrs_pkg::qrs_div_side_t side_in;
      logic [1:0][NW-1:0]     nq_nxt;
      logic [1:0][DW-1:0]     rem_nxt;

      if (k == 0) begin : g_first
        assign valid_in = in_valid;
        assign nq_in    = in_num;
        assign rem_in   = '0;
        assign dvs_in   = in_dvs;
        assign side_in  = in_side;
      end else begin : g_next
        assign valid_in = valid_r[k-1];
        assign nq_in    = nq_r[k-1];
        assign rem_in   = rem_r[k-1];
        assign dvs_in   = dvs_r[k-1];
        assign side_in  = side_r[k-1];
      end

      // numerator shifts out the top while quotient bits enter the bottom
      always_comb begin
        logic [DW:0] rem_sh;
        logic [DW:0] diff;
        logic        ge;
        for (int l = 0; l < 2; l++) begin
          rem_sh     = {rem_in[l], nq_in[l][NW-1]};
          diff       = rem_sh - {1'b0, dvs_in};
          ge         = rem_sh >= {1'b0, dvs_in};
          rem_nxt[l] = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
          nq_nxt[l]  = {nq_in[l][NW-2:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else begin
          valid_r[k] <= valid_in;
        end
      end

      always_ff @(posedge clk) begin
        nq_r[k]   <= nq_nxt;
        rem_r[k]  <= rem_nxt;
        dvs_r[k]  <= dvs_in;
        side_r[k] <= side_in;
      end
    end
  endgenerate

  assign out_valid = valid_r[NW-1];
  assign out_quo   = nq_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule
`default_nettype wire

@@ rtl/quadratic_root_solver_unit.sv @@
// quadratic root solver top level: discriminant, square root, divide, clamp
//
// Takes one coefficient triple (a, b, c, signed Q8.8) on start when busy is
// low and returns one result on out_valid, held for one cycle only; the
// receiver cannot stall. A new triple may enter every cycle.
// The pipeline registers the products, then the discriminant, then the
// square root (one root bit per stage), the numerators, the divide by 2a
// (one quotient bit per stage) and the clamp. busy is high during reset
// and in the cycle after reset, and low otherwise.
// Roots are signed Q16.16, truncated toward zero and clamped with the
// saturated flag; a zero a reports a degenerate kind with zero results.
`default_nettype none
`include "quadratic_root_solver_unit_defines.svh"
module quadratic_root_solver_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire qrs_pkg::qrs_in_t in_data,
  output logic                  out_valid,
  output qrs_pkg::qrs_out_t     out_data
);

  localparam int CW = qrs_pkg::COEF_WIDTH;
  localparam int PW = qrs_pkg::PROD_W;
  localparam int DW = qrs_pkg::DISC_W;
  localparam int NW = qrs_pkg::NUM_W;
  localparam int RW = qrs_pkg::RESULT_WIDTH;
  localparam int VW = qrs_pkg::DIVS_W;
  localparam int BW = qrs_pkg::NB_W;

  localparam logic [NW-1:0] MAG_POS = {{(NW-RW+1){1'b0}}, {(RW-1){1'b1}}};
  localparam logic [NW-1:0] MAG_NEG = MAG_POS + 1'b1;

  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // stage 1: products
  logic                 s1_valid_r;
  logic signed [CW-1:0] s1_a_r, s1_b_r;
  logic signed [PW-1:0] s1_bb_r, s1_ac_r;
  logic signed [PW-1:0] bb_nxt, ac_nxt;

  always_comb begin
    bb_nxt = PW'(in_data.coef_b) * PW'(in_data.coef_b);
    ac_nxt = PW'(in_data.coef_a) * PW'(in_data.coef_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r  <= in_data.coef_a;
    s1_b_r  <= in_data.coef_b;
    s1_bb_r <= bb_nxt;
    s1_ac_r <= ac_nxt;
  end

  // stage 2: discriminant and classification
  logic                          s2_valid_r;
  logic [qrs_pkg::DMAG_W-1:0]    s2_dmag_r;
  qrs_pkg::qrs_sq_side_t         s2_side_r;
  logic signed [DW-1:0]          disc;
  logic signed [DW-1:0]          disc_abs;
  qrs_pkg::qrs_sq_side_t         side_nxt;

  always_comb begin
    disc           = DW'(s1_bb_r) - (DW'(s1_ac_r) <<< 2);
    disc_abs       = disc[DW-1] ? -disc : disc;
    side_nxt.nb    = -(BW'(s1_b_r) <<< qrs_pkg::RESULT_FRAC);
    side_nxt.two_a = VW'(s1_a_r) <<< 1;
    if (s1_a_r == '0) begin
      side_nxt.kind = qrs_pkg::KIND_DEGEN;
    end else if (disc[DW-1]) begin
      side_nxt.kind = qrs_pkg::KIND_COMPLEX;
    end else if (disc == '0) begin
      side_nxt.kind = qrs_pkg::KIND_DOUBLE;
    end else begin
      side_nxt.kind = qrs_pkg::KIND_TWO_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_dmag_r <= disc_abs[qrs_pkg::DMAG_W-1:0];
    s2_side_r <= side_nxt;
  end

  logic                       sq_valid;
  logic [qrs_pkg::SQRT_W-1:0] sq_root;
  qrs_pkg::qrs_sq_side_t      sq_side;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_dmag   (s2_dmag_r),
    .in_side   (s2_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage 3: numerators as sign and magnitude
  logic                   s3_valid_r;
  logic [1:0][NW-1:0]     s3_num_r;
  logic [VW-1:0]          s3_dvs_r;
  qrs_pkg::qrs_div_side_t s3_side_r;
  logic [1:0][NW-1:0]     num_nxt;
  logic [VW-1:0]          dvs_nxt;
  qrs_pkg::qrs_div_side_t dside_nxt;

  always_comb begin
    logic signed [NW:0] nbx;
    logic signed [NW:0] sx;
    logic signed [NW:0] n [0:1];
    logic signed [NW:0] nabs;
    nbx = (NW+1)'(sq_side.nb);
    sx  = {{(NW+1-qrs_pkg::SQRT_W){1'b0}}, sq_root};
    if (sq_side.kind == qrs_pkg::KIND_COMPLEX) begin
      n[0] = nbx;
      n[1] = sx;
    end else begin
      n[0] = nbx + sx;
      n[1] = nbx - sx;
    end
    for (int l = 0; l < 2; l++) begin
      nabs          = n[l][NW] ? -n[l] : n[l];
      num_nxt[l]    = nabs[NW-1:0];
      dside_nxt.neg[l] = n[l][NW] ^ sq_side.two_a[VW-1];
    end
    dvs_nxt        = sq_side.two_a[VW-1] ? VW'(-sq_side.two_a) : VW'(sq_side.two_a);
    dside_nxt.kind = sq_side.kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_num_r  <= num_nxt;
    s3_dvs_r  <= dvs_nxt;
    s3_side_r <= dside_nxt;
  end

  logic                   dv_valid;
  logic [1:0][NW-1:0]     dv_quo;
  qrs_pkg::qrs_div_side_t dv_side;

  qrs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid_r),
    .in_num    (s3_num_r),
    .in_dvs    (s3_dvs_r),
    .in_side   (s3_side_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // stage 4: sign, clamp and output register
  logic              out_valid_r;
  qrs_pkg::qrs_out_t out_data_r;
  qrs_pkg::qrs_out_t out_nxt;

  always_comb begin
    logic [1:0][RW-1:0] val;
    logic [1:0]         sat;
    logic [NW-1:0]      qneg;
    for (int l = 0; l < 2; l++) begin
      qneg = -dv_quo[l];
      if (dv_side.neg[l]) begin
        sat[l] = dv_quo[l] > MAG_NEG;
        val[l] = sat[l] ? {1'b1, {(RW-1){1'b0}}} : qneg[RW-1:0];
      end else begin
        sat[l] = dv_quo[l] > MAG_POS;
        val[l] = sat[l] ? {1'b0, {(RW-1){1'b1}}} : dv_quo[l][RW-1:0];
      end
    end
    out_nxt.root_kind = dv_side.kind;
    if (dv_side.kind == qrs_pkg::KIND_DEGEN) begin
      out_nxt.first_value  = '0;
      out_nxt.second_value = '0;
      out_nxt.saturated    = 1'b0;
    end else begin
      out_nxt.first_value  = val[0];
      out_nxt.second_value = val[1];
      out_nxt.saturated    = |sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `QRS_ASSERT_NEXT(a_no_result_after_reset, !rst_n, !out_valid, "result strobe right after reset")
  `QRS_ASSERT_NOW(a_busy_only_after_reset, $past(rst_n), !busy, "busy outside reset recovery")
  `QRS_ASSERT_NOW(a_degen_zero, out_valid && out_data.root_kind == qrs_pkg::KIND_DEGEN, out_data.first_value == '0 && out_data.second_value == '0 && !out_data.saturated, "degenerate result not zero")
  `QRS_ASSERT_NOW(a_double_equal, out_valid && out_data.root_kind == qrs_pkg::KIND_DOUBLE, out_data.first_value == out_data.second_value, "double root halves differ")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the quadratic root solver: directed and random coefficient triples
module tb_top;
  import qrs_pkg::*;

  localparam int LATENCY   = 71;
  localparam int WD_LIMIT  = 4000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  qrs_in_t  in_data = '0;
  logic     out_valid;
  qrs_out_t out_data;

  qrs_out_t roots_due[$];
  int       fail_count = 0;
  int       sent_count = 0;
  int       got_count = 0;
  int       kind_seen[4] = '{0, 0, 0, 0};
  int       idle_cycles = 0;

  quadratic_root_solver_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // floor(sqrt(d) * 2^16)
  function automatic longint unsigned frac_sqrt(longint unsigned d);
    longint unsigned rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int i = 32 + RESULT_FRAC - 1; i >= 0; i--) begin
      pair = (2 * i >= 2 * RESULT_FRAC) ? ((d >> (2 * i - 2 * RESULT_FRAC)) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint clamp_q16(longint v, ref logic sat);
    longint hi, lo;
    hi = 64'sd2147483647;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic qrs_out_t solve_roots(qrs_in_t t);
    qrs_out_t r;
    longint a, b, c, d, two_a, nb, r1, r2, s;
    logic sat;
    a = t.coef_a;
    b = t.coef_b;
    c = t.coef_c;
    sat = 1'b0;
    r = '0;
    if (a == 0) begin
      r.root_kind = KIND_DEGEN;
      return r;
    end
    d = b * b - 4 * a * c;
    two_a = 2 * a;
    nb = -b * (64'sd1 << RESULT_FRAC);
    if (d > 0) begin
      r.root_kind = KIND_TWO_REAL;
      s = longint'(frac_sqrt(d));
      r1 = (nb + s) / two_a;
      r2 = (nb - s) / two_a;
    end else if (d == 0) begin
      r.root_kind = KIND_DOUBLE;
      r1 = nb / two_a;
      r2 = r1;
    end else begin
      r.root_kind = KIND_COMPLEX;
      s = longint'(frac_sqrt(-d));
      r1 = nb / two_a;
      r2 = s / two_a;
    end
    r1 = clamp_q16(r1, sat);
    r2 = clamp_q16(r2, sat);
    r.first_value = r1[31:0];
    r.second_value = r2[31:0];
    r.saturated = sat;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    qrs_out_t want;
    if (rst_n && out_valid) begin
      got_count++;
      if (roots_due.size() == 0) begin
        $error("result with no transaction pending: %p", out_data);
        fail_count++;
      end else begin
        want = roots_due.pop_front();
        kind_seen[want.root_kind]++;
        if (out_data.root_kind !== want.root_kind) begin
          $error("root_kind expected %0d got %0d", want.root_kind, out_data.root_kind);
          fail_count++;
        end
        if (out_data.first_value !== want.first_value) begin
          $error("first_value expected %0d got %0d", want.first_value,
                 out_data.first_value);
          fail_count++;
        end
        if (out_data.second_value !== want.second_value) begin
          $error("second_value expected %0d got %0d", want.second_value,
                 out_data.second_value);
          fail_count++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated expected %0d got %0d", want.saturated, out_data.saturated);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return;
    repeat (pick < 90 ? $urandom_range(1, 3) : $urandom_range(10, 120)) @(negedge clk);
  endtask

  task automatic send_triple(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c, bit gaps);
    qrs_in_t t;
    t.coef_a = a;
    t.coef_b = b;
    t.coef_c = c;
    start <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    roots_due.push_back(solve_roots(t));
    sent_count++;
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      in_data <= qrs_in_t'({$urandom, 16'($urandom)});
      @(negedge clk);
      idle_gap();
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (roots_due.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_triple(16'sh0000, 16'sh1234, -16'sh0100, 0);
    send_triple(16'sh0000, 16'sh0000, 16'sh0000, 0);
    send_triple(16'sh0100, 16'sh0000, -16'sh0400, 0);
    send_triple(16'sh0100, -16'sh0200, 16'sh0100, 0);
    send_triple(16'sh0100, 16'sh0000, 16'sh0100, 0);
    send_triple(-16'sh0100, 16'sh0000, -16'sh0100, 0);
    send_triple(-16'sh0100, 16'sh0200, 16'sh0300, 0);
    send_triple(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_triple(-16'sh8000, -16'sh8000, -16'sh8000, 0);
    send_triple(-16'sh8000, 16'sh7fff, 16'sh7fff, 0);
    send_triple(16'sh0001, 16'sh7fff, 16'sh0000, 0);
    send_triple(16'sh0001, -16'sh8000, 16'sh7fff, 0);
    send_triple(-16'sh0001, 16'sh0000, -16'sh8000, 0);
    send_triple(16'sh0001, 16'sh0000, -16'sh8000, 0);
    send_triple(16'sh7fff, 16'sh0000, -16'sh0001, 0);
    send_triple(16'sh0001, 16'sh0002, 16'sh0001, 0);
    send_triple(16'shffff, 16'sh5555, 16'shaaaa, 0);
    send_triple(16'sh0040, 16'sh0000, 16'sh0000, 0);
  endtask

  task automatic test_pause_until_empty();
    drain();
  endtask

  task automatic test_random(int count);
    logic signed [15:0] a, b, c, r;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      case (mode)
        0: a = 16'sh0000;
        1: begin
          // perfect square: (x - r)^2 scaled so d is zero
          r = $signed(16'($urandom_range(0, 255))) - 16'sd128;
          a = 16'sh0001;
          b = 16'(-2 * r);
          c = r * r;
        end
        2, 3: begin
          a = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
          if (a == 0) a = 16'sh0001;
        end
        4: b = 16'sh0000;
        default: ;
      endcase
      send_triple(a, b, c, 1);
    end
  endtask

  task automatic test_back_to_back(int count);
    for (int i = 0; i < count; i++)
      send_triple(16'($urandom), 16'($urandom), 16'($urandom), 0);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_pause_until_empty();
    test_random(1200);
    test_back_to_back(200);
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    $display("sent %0d coefficient triples, checked %0d results", sent_count, got_count);
    $display("kinds: two real %0d, double %0d, complex %0d, degenerate %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (fail_count == 0 && roots_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/qrs_pkg.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver_unit.sv
tb/tb_top.sv
